// ----- rtl/pca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_pkg
// Shared widths, codes and the command word for the capacity allocator.
// ----------------------------------------------------------------------------
package pca_pkg;

	localparam int ID_W    = 5;
	localparam int BL_W    = 48;
	localparam int FR_W    = 32;
	localparam int SL_W    = 16;
	localparam int BPS_W   = 32;
	localparam int CAP_W   = SL_W + BPS_W;
	localparam int OTOT_W  = 53;
	localparam int PROD_W  = CAP_W + BL_W;
	localparam int HALF_W  = 24;
	localparam int MAX_STATIONS_DEF = 32;

	localparam logic [1:0] OP_REPORT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_PLAN   = 2'd2;

	localparam logic [1:0] KIND_ENTRY = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]      opcode;
		logic [ID_W-1:0] station_id;
		logic [BL_W-1:0] backlog_bits;
		logic [FR_W-1:0] frame_number;
		logic [SL_W-1:0] dedicated_slots;
	} cmd_t;

endpackage

// ----- rtl/proportional_capacity_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proportional_capacity_allocator
// Per-station backlog table with query and proportional plan generation.
// Reports write the table, queries read it; a plan sums every valid entry, then
// gives one word per valid entry (one empty word if none), scaled by a 4-step
// multiply and a 96-step divider when the total exceeds a nonzero capacity.
// Throughput: one report per cycle while idle; receiver cannot stall.
// Reset clears the valid marks, bits_per_slot and the queue; table data is kept.
// ----------------------------------------------------------------------------
module proportional_capacity_allocator import pca_pkg::*; #(
	parameter int MAX_STATIONS = MAX_STATIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        opcode,
	input  logic [ID_W-1:0]   station_id,
	input  logic [BL_W-1:0]   backlog_bits,
	input  logic [FR_W-1:0]   frame_number,
	input  logic [SL_W-1:0]   dedicated_slots,
	input  logic              cfg_we,
	input  logic [BPS_W-1:0]  cfg_wdata,
	output logic              strobe,
	output logic [1:0]        kind,
	output logic [ID_W-1:0]   station_out,
	output logic [BL_W-1:0]   amount,
	output logic [FR_W-1:0]   frame_out,
	output logic [OTOT_W-1:0] total_backlog,
	output logic              last
);

	logic head_valid;
	cmd_t head;
	logic pop;

	pca_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.station_id(station_id), .backlog_bits(backlog_bits),
		.frame_number(frame_number), .dedicated_slots(dedicated_slots),
		.busy(busy), .head_valid(head_valid), .head(head), .pop(pop)
	);

	pca_back #(.MAX_STATIONS(MAX_STATIONS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.head_valid(head_valid), .head(head), .pop(pop), .strobe(strobe),
		.kind(kind), .station_out(station_out), .amount(amount),
		.frame_out(frame_out), .total_backlog(total_backlog), .last(last)
	);

endmodule

// ----- rtl/pca_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_front
// Accepts command words, drops unknown opcodes and queues the rest.
// ----------------------------------------------------------------------------
module pca_front import pca_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      opcode,
	input  logic [ID_W-1:0] station_id,
	input  logic [BL_W-1:0] backlog_bits,
	input  logic [FR_W-1:0] frame_number,
	input  logic [SL_W-1:0] dedicated_slots,
	output logic            busy,
	output logic            head_valid,
	output cmd_t            head,
	input  logic            pop
);

	cmd_t       entry_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       do_pop;

	assign busy       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rptr_q];
	assign push       = start && !busy && (opcode != 2'd3);
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (do_pop) rptr_q <= !rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= '{opcode: opcode, station_id: station_id,
				backlog_bits: backlog_bits, frame_number: frame_number,
				dedicated_slots: dedicated_slots};
		end
	end

endmodule

// ----- rtl/pca_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_back
// Executes queued words: table writes, queries and plan generation with
// a split multiplier and a restoring divider.
// ----------------------------------------------------------------------------
module pca_back import pca_pkg::*; #(
	parameter int MAX_STATIONS = MAX_STATIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [BPS_W-1:0]  cfg_wdata,
	input  logic              head_valid,
	input  cmd_t              head,
	output logic              pop,
	output logic              strobe,
	output logic [1:0]        kind,
	output logic [ID_W-1:0]   station_out,
	output logic [BL_W-1:0]   amount,
	output logic [FR_W-1:0]   frame_out,
	output logic [OTOT_W-1:0] total_backlog,
	output logic              last
);

	localparam int AW    = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
	localparam int TOT_W = BL_W + $clog2(MAX_STATIONS);
	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_STATIONS - 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_QRD  = 4'd1;
	localparam logic [3:0] ST_SRD  = 4'd2;
	localparam logic [3:0] ST_SACC = 4'd3;
	localparam logic [3:0] ST_ASCN = 4'd4;
	localparam logic [3:0] ST_AGET = 4'd5;
	localparam logic [3:0] ST_MUL  = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;

	logic [BL_W-1:0]   mem [MAX_STATIONS];
	logic [BL_W-1:0]   rdata_q;
	logic [AW-1:0]     rd_addr;
	logic [MAX_STATIONS-1:0] valid_q;

	logic [3:0]        state_q;
	logic [BPS_W-1:0]  bps_q;
	logic [CAP_W-1:0]  cap_q;
	logic [TOT_W-1:0]  total_q;
	logic [FR_W-1:0]   frame_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     lastidx_q;
	logic [ID_W-1:0]   qid_q;
	logic              qok_q;
	logic [BL_W-1:0]   b_q;
	logic [2:0]        mstep_q;
	logic [1:0]        sh_q;
	logic [2*HALF_W-1:0] pp_q;
	logic [PROD_W-1:0] prod_q;
	logic [TOT_W:0]    rem_q;
	logic [BL_W-1:0]   quo_q;
	logic [6:0]        dcnt_q;

	logic              in_range;
	logic [TOT_W:0]    trial;
	logic              take;
	logic [HALF_W-1:0] a_part;
	logic [HALF_W-1:0] b_part;
	logic [PROD_W-1:0] pp_sh;
	logic [TOT_W-1:0]  cap_ext;

	assign in_range = (32'(head.station_id) < MAX_STATIONS);
	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign cap_ext  = TOT_W'(cap_q);
	assign trial    = {rem_q[TOT_W-1:0], prod_q[PROD_W-1]};
	assign take     = (trial >= {1'b0, total_q});

	always_comb begin
		case (state_q)
			ST_IDLE: rd_addr = AW'(head.station_id);
			default: rd_addr = idx_q;
		endcase
	end

	always_comb begin
		case (mstep_q)
			3'd0: begin a_part = cap_q[HALF_W-1:0];      b_part = b_q[HALF_W-1:0];      end
			3'd1: begin a_part = cap_q[2*HALF_W-1:HALF_W]; b_part = b_q[HALF_W-1:0];    end
			3'd2: begin a_part = cap_q[HALF_W-1:0];      b_part = b_q[2*HALF_W-1:HALF_W]; end
			default: begin
				a_part = cap_q[2*HALF_W-1:HALF_W];
				b_part = b_q[2*HALF_W-1:HALF_W];
			end
		endcase
	end

	always_comb begin
		case (sh_q)
			2'd0:    pp_sh = PROD_W'(pp_q);
			2'd1:    pp_sh = PROD_W'(pp_q) << HALF_W;
			default: pp_sh = PROD_W'(pp_q) << (2 * HALF_W);
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (state_q == ST_IDLE && head_valid && head.opcode == OP_REPORT && in_range)
			mem[AW'(head.station_id)] <= head.backlog_bits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			bps_q   <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (cfg_we) bps_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						case (head.opcode)
							OP_REPORT: begin
								if (in_range) valid_q[AW'(head.station_id)] <= 1'b1;
							end
							OP_QUERY: state_q <= ST_QRD;
							OP_PLAN: begin
								if (valid_q == '0) begin
									strobe <= 1'b1;
								end else begin
									state_q <= ST_SRD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_QRD: begin
					strobe  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SRD:  state_q <= ST_SACC;
				ST_SACC: state_q <= (idx_q == LAST_IDX) ? ST_ASCN : ST_SRD;
				ST_ASCN: if (valid_q[idx_q]) state_q <= ST_AGET;
				ST_AGET: begin
					if (cap_q == '0 || total_q == '0 || total_q <= cap_ext) begin
						strobe  <= 1'b1;
						state_q <= (idx_q == lastidx_q) ? ST_IDLE : ST_ASCN;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: if (mstep_q == 3'd4) state_q <= ST_DIV;
				ST_DIV: begin
					if (dcnt_q == 7'(PROD_W - 1)) begin
						strobe  <= 1'b1;
						state_q <= (idx_q == lastidx_q) ? ST_IDLE : ST_ASCN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				qid_q   <= head.station_id;
				qok_q   <= in_range && valid_q[AW'(head.station_id)];
				frame_q <= head.frame_number;
				cap_q   <= CAP_W'(head.dedicated_slots) * CAP_W'(bps_q);
				total_q <= '0;
				idx_q   <= '0;
				kind          <= KIND_EMPTY;
				station_out   <= '0;
				amount        <= '0;
				frame_out     <= head.frame_number;
				total_backlog <= '0;
				last          <= 1'b1;
			end
			ST_QRD: begin
				kind          <= KIND_QUERY;
				station_out   <= qid_q;
				amount        <= qok_q ? rdata_q : '0;
				frame_out     <= '0;
				total_backlog <= '0;
				last          <= 1'b1;
			end
			ST_SACC: begin
				if (valid_q[idx_q]) begin
					total_q   <= total_q + TOT_W'(rdata_q);
					lastidx_q <= idx_q;
				end
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			end
			ST_ASCN: if (!valid_q[idx_q]) idx_q <= idx_q + 1'b1;
			ST_AGET: begin
				b_q     <= rdata_q;
				mstep_q <= '0;
				prod_q  <= '0;
				kind          <= KIND_ENTRY;
				station_out   <= ID_W'(idx_q);
				amount        <= (cap_q == '0 || total_q == '0) ? '0 : rdata_q;
				frame_out     <= frame_q;
				total_backlog <= OTOT_W'(total_q);
				last          <= (idx_q == lastidx_q);
				if (cap_q == '0 || total_q == '0 || total_q <= cap_ext)
					idx_q <= idx_q + 1'b1;
			end
			ST_MUL: begin
				if (mstep_q != 3'd4) begin
					pp_q <= a_part * b_part;
					case (mstep_q)
						3'd0:    sh_q <= 2'd0;
						3'd3:    sh_q <= 2'd2;
						default: sh_q <= 2'd1;
					endcase
				end
				if (mstep_q != 3'd0) prod_q <= prod_q + pp_sh;
				mstep_q <= mstep_q + 3'd1;
				rem_q   <= '0;
				quo_q   <= '0;
				dcnt_q  <= '0;
			end
			ST_DIV: begin
				rem_q  <= take ? (trial - {1'b0, total_q}) : trial;
				quo_q  <= {quo_q[BL_W-2:0], take};
				prod_q <= {prod_q[PROD_W-2:0], 1'b0};
				dcnt_q <= dcnt_q + 7'd1;
				if (dcnt_q == 7'(PROD_W - 1)) begin
					amount <= {quo_q[BL_W-2:0], take};
					idx_q  <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/pca_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_checker
// Port-level checks on the result words of the capacity allocator.
// ----------------------------------------------------------------------------
module pca_checker import pca_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              strobe,
	input logic [1:0]        kind,
	input logic [BL_W-1:0]   amount,
	input logic [FR_W-1:0]   frame_out,
	input logic [OTOT_W-1:0] total_backlog,
	input logic              last
);

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (kind == KIND_ENTRY || kind == KIND_QUERY || kind == KIND_EMPTY))
		else $error("bad result kind");

	a_query: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_QUERY |-> last && frame_out == '0 && total_backlog == '0)
		else $error("bad query word");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_EMPTY |-> last && amount == '0 && total_backlog == '0)
		else $error("bad empty plan word");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_ENTRY && amount != '0 |-> total_backlog != '0)
		else $error("allocation with zero total");

endmodule

bind proportional_capacity_allocator pca_checker u_pca_checker (
	.clk(clk), .arst_n(arst_n), .strobe(strobe), .kind(kind), .amount(amount),
	.frame_out(frame_out), .total_backlog(total_backlog), .last(last)
);

// ----- tb/sv/proportional_capacity_allocator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proportional_capacity_allocator_test
// Drives reports, queries, plans and unknown opcodes into the allocator under
// several bits-per-slot settings, predicts every result word with an integer
// model of the backlog table and proportional split, and compares whole words.
// ----------------------------------------------------------------------------
module proportional_capacity_allocator_test;
	import pca_pkg::*;

	localparam int NST = 32;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ID_W-1:0]   station;
		logic [BL_W-1:0]   amount;
		logic [FR_W-1:0]   frame;
		logic [OTOT_W-1:0] total;
		logic              last;
	} alloc_word_t;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              start = 0;
	logic              busy;
	logic [1:0]        opcode = OP_REPORT;
	logic [ID_W-1:0]   station_id = '0;
	logic [BL_W-1:0]   backlog_bits = '0;
	logic [FR_W-1:0]   frame_number = '0;
	logic [SL_W-1:0]   dedicated_slots = '0;
	logic              cfg_we = 0;
	logic [BPS_W-1:0]  cfg_wdata = '0;
	logic              strobe;
	logic [1:0]        kind;
	logic [ID_W-1:0]   station_out;
	logic [BL_W-1:0]   amount;
	logic [FR_W-1:0]   frame_out;
	logic [OTOT_W-1:0] total_backlog;
	logic              last;

	proportional_capacity_allocator #(.MAX_STATIONS(NST)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .station_id(station_id), .backlog_bits(backlog_bits),
		.frame_number(frame_number), .dedicated_slots(dedicated_slots),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .strobe(strobe), .kind(kind),
		.station_out(station_out), .amount(amount), .frame_out(frame_out),
		.total_backlog(total_backlog), .last(last)
	);

	initial forever #2 clk = ~clk;

	logic [BL_W-1:0]  backlog_mem [NST];
	logic             reported [NST];
	logic [BPS_W-1:0] slot_bits;
	alloc_word_t      pending_allocs [$];
	int               mismatches = 0;
	int               words_seen = 0;
	int               items_sent = 0;
	int               idle_cycles = 0;
	logic             hot_ids = 0;

	function automatic alloc_word_t make_word(logic [1:0] k, logic [ID_W-1:0] s,
			logic [BL_W-1:0] a, logic [FR_W-1:0] f, logic [OTOT_W-1:0] t, logic l);
		alloc_word_t w;
		w.kind = k; w.station = s; w.amount = a; w.frame = f; w.total = t; w.last = l;
		return w;
	endfunction

	function automatic void queue_word(alloc_word_t w);
		pending_allocs.insert(pending_allocs.size(), w);
	endfunction

	task automatic predict_allocs(logic [1:0] op, logic [ID_W-1:0] id,
			logic [BL_W-1:0] bl, logic [FR_W-1:0] fr, logic [SL_W-1:0] sl);
		logic [CAP_W-1:0]  capacity;
		logic [63:0]       demand;
		logic [PROD_W-1:0] share;
		logic [BL_W-1:0]   amt;
		int                top;
		demand = 0;
		top = -1;
		case (op)
			OP_REPORT: begin
				backlog_mem[id] = bl;
				reported[id] = 1;
			end
			OP_QUERY: begin
				queue_word(make_word(KIND_QUERY, id,
					reported[id] ? backlog_mem[id] : '0, '0, '0, 1'b1));
			end
			OP_PLAN: begin
				capacity = CAP_W'(sl) * CAP_W'(slot_bits);
				for (int i = 0; i < NST; i++)
					if (reported[i]) begin
						demand += backlog_mem[i];
						top = i;
					end
				if (top < 0)
					queue_word(make_word(KIND_EMPTY, '0, '0, fr, '0, 1'b1));
				for (int i = 0; i < NST; i++)
					if (reported[i]) begin
						if (capacity == 0 || demand == 0)
							amt = '0;
						else if (demand <= capacity)
							amt = backlog_mem[i];
						else begin
							share = (PROD_W'(capacity) * PROD_W'(backlog_mem[i]))
								/ PROD_W'(demand);
							amt = share[BL_W-1:0];
						end
						queue_word(make_word(KIND_ENTRY, ID_W'(i), amt, fr,
							demand[OTOT_W-1:0], i == top));
					end
			end
			default: ;
		endcase
	endtask

	task automatic send_word(logic [1:0] op, logic [ID_W-1:0] id,
			logic [BL_W-1:0] bl, logic [FR_W-1:0] fr, logic [SL_W-1:0] sl, int gap);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(negedge clk);
		end
		opcode <= op; station_id <= id; backlog_bits <= bl;
		frame_number <= fr; dedicated_slots <= sl;
		start <= 1;
		do @(posedge clk); while (busy);
		predict_allocs(op, id, bl, fr, sl);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_slot_bits(logic [BPS_W-1:0] v);
		start <= 0;
		wait (pending_allocs.size() == 0);
		repeat (4 * NST + 120) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		slot_bits = v;
	endtask

	function automatic logic [BL_W-1:0] rand_backlog();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return BL_W'($urandom_range(0, 1000));
			default: return BL_W'({$urandom, $urandom});
		endcase
	endfunction

	function automatic int rand_gap();
		return hot_ids ? 0 : $urandom_range(0, 11);
	endfunction

	task automatic test_directed();
		send_word(OP_PLAN, '0, '0, '1, '1, 0);
		send_word(OP_QUERY, 5'd31, '0, '0, '0, 0);
		send_word(2'd3, 5'd7, '1, '1, '1, 0);
		send_word(OP_REPORT, 5'd0, '1, '0, '0, 0);
		send_word(OP_REPORT, 5'd31, '0, '0, '0, 0);
		send_word(OP_QUERY, 5'd0, '0, '0, '0, 0);
		send_word(OP_QUERY, 5'd31, '0, '0, '0, 0);
		send_word(OP_PLAN, '0, '0, 32'h1234_5678, 16'd100, 0);
		write_slot_bits('1);
		send_word(OP_PLAN, '0, '0, '0, '1, 0);
		send_word(OP_PLAN, '0, '0, 32'd7, 16'd1, 0);
		send_word(OP_PLAN, '0, '0, 32'd8, '0, 0);
		send_word(OP_REPORT, 5'd0, '0, '0, '0, 0);
		send_word(OP_PLAN, '0, '0, 32'd9, 16'd3, 0);
		send_word(OP_REPORT, 5'd16, 48'hAAAA_5555_AAAA, '0, '0, 0);
		send_word(OP_REPORT, 5'd15, 48'h5555_AAAA_5555, '0, '0, 0);
		send_word(OP_PLAN, '0, '0, 32'hFFFF_0000, 16'd2, 0);
		write_slot_bits(32'd1);
		send_word(OP_PLAN, '0, '0, 32'h0000_FFFF, 16'd10, 0);
	endtask

	task automatic test_random_traffic();
		logic [1:0] op;
		for (int n = 0; n < 210; n++) begin
			if (n % 70 == 69)
				write_slot_bits($urandom_range(0, 3) == 0 ? BPS_W'($urandom_range(0, 9))
					: $urandom);
			hot_ids = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 19))
				0: op = 2'd3;
				1, 2, 3: op = OP_PLAN;
				4, 5, 6, 7, 8: op = OP_QUERY;
				default: op = OP_REPORT;
			endcase
			send_word(op, ID_W'($urandom), rand_backlog(), $urandom,
				$urandom_range(0, 3) == 0 ? SL_W'($urandom_range(0, 4)) : SL_W'($urandom),
				rand_gap());
		end
	endtask

	always @(posedge clk) begin
		alloc_word_t got, want;
		if (arst_n && strobe) begin
			got = make_word(kind, station_out, amount, frame_out, total_backlog, last);
			words_seen++;
			if (pending_allocs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: kind %0d station %0d amount %0h",
						kind, station_out, amount);
			end else begin
				want = pending_allocs.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected k%0d s%0d a%h f%h t%h l%0d, got k%0d s%0d a%h f%h t%h l%0d",
							want.kind, want.station, want.amount, want.frame,
							want.total, want.last, got.kind, got.station, got.amount,
							got.frame, got.total, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NST; i++) begin
			reported[i] = 0;
			backlog_mem[i] = '0;
		end
		slot_bits = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		test_directed();
		test_random_traffic();
		start <= 0;
		wait (pending_allocs.size() == 0);
		repeat (40) @(negedge clk);
		$display("Sent %0d commands, checked %0d result words (reports, queries, plans).",
			items_sent, words_seen);
		if (mismatches == 0 && pending_allocs.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/pca_pkg.sv
rtl/pca_front.sv
rtl/pca_back.sv
rtl/proportional_capacity_allocator.sv
rtl/pca_checker.sv
tb/sv/proportional_capacity_allocator_test.sv
